// ----- rtl/mms_pkg.sv -----
// Package for the mouse motion smoother: shared types, codes and constants.
// Used by the arithmetic unit, the top level and the checker.
`timescale 1ns / 1ps
`default_nettype none
package mms_pkg;

    localparam int COUNT_WIDTH_DEF = 32;
    localparam int DW              = 64;
    localparam int DIV_STEPS       = 64;
    localparam int MUL_STEPS       = 20;
    localparam int STEP_W          = 7;

    typedef enum logic [1:0] {
        OP_MUL = 2'b01,
        OP_DIV = 2'b10
    } op_t;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    localparam logic CFG_SMOOTH_EN  = 1'b0;
    localparam logic CFG_SAMPLE_INT = 1'b1;

    localparam logic [19:0] SAMPLE_INTERVAL_RST = 20'd6000;
    localparam logic [31:0] SAMPLING_TIME_RST   = 32'd8000;
    localparam logic [23:0] DT_LIMIT            = 24'd250000;
    localparam logic [18:0] FRAC_CAP            = 19'h40000;
    localparam logic [DW-1:0] OUT_SCALE         = 64'd250;

    typedef struct packed {
        logic            start;
        op_t             op;
        logic [DW-1:0]   a;
        logic [DW-1:0]   b;
    } arith_req_t;

    typedef struct packed {
        logic            done;
        logic [DW-1:0]   result;
    } arith_rsp_t;

endpackage
`default_nettype wire

// ----- rtl/mouse_motion_smoother.sv -----
// Mouse motion smoother: a motion event yields one wheel result the next cycle; a frame
// tick below the sample interval yields nothing. A tick that closes the interval runs
// both axes through the shared multiply/divide unit as scaling and smoothing need it.
// One item is in work at a time. Reset is synchronous, active low, and restores the
// control and state registers; the datapath and output data registers are not reset.
`timescale 1ns / 1ps
`default_nettype none
module mouse_motion_smoother #(
    parameter int COUNT_WIDTH = mms_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // rel_x, rel_y, wheel_abs, wheel_rel, frame_delta_us, frame_number
    input  wire logic [119:0] s_tdata,
    // kind
    input  wire logic [0:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // rel_value, abs_value
    output logic [31:0]       m_tdata,
    // axis
    output logic [1:0]        m_tuser,
    output logic              m_tlast,
    input  wire logic         cfg_wr_en,
    input  wire logic [0:0]   cfg_addr,
    input  wire logic [19:0]  cfg_wr_data
);

    localparam int DW = mms_pkg::DW;

    typedef enum logic [12:0] {
        ST_IDLE   = 13'b0000000000001,
        ST_AX     = 13'b0000000000010,
        ST_WAIT   = 13'b0000000000100,
        ST_SPS    = 13'b0000000001000,
        ST_FRAC   = 13'b0000000010000,
        ST_MF_HI  = 13'b0000000100000,
        ST_MF_LO  = 13'b0000001000000,
        ST_MF_SUM = 13'b0000010000000,
        ST_NDIV   = 13'b0000100000000,
        ST_NQ     = 13'b0001000000000,
        ST_SCALE  = 13'b0010000000000,
        ST_SDIV   = 13'b0100000000000,
        ST_EMIT   = 13'b1000000000000
    } state_t;

    function automatic logic [31:0] sat32(input logic neg, input logic [DW-1:0] mag);
        logic [31:0] r;
        if (!neg) r = (mag > 64'h7FFFFFFF) ? 32'h7FFFFFFF : mag[31:0];
        else      r = (mag > 64'h80000000) ? 32'h80000000 : (~mag[31:0] + 32'd1);
        return r;
    endfunction

    function automatic logic [31:0] addu32(input logic [31:0] a, input logic [23:0] b);
        logic [32:0] s;
        s = {1'b0, a} + 33'(b);
        return s[32] ? 32'hFFFFFFFF : s[31:0];
    endfunction

    state_t                 state_reg, state_next;
    state_t                 ret_reg, ret_next;
    logic                   axis_reg, axis_next;
    logic                   en_reg, en_next;
    logic [19:0]            intv_reg, intv_next;
    logic [31:0]            acc_reg [2];
    logic [31:0]            acc_next [2];
    logic [31:0]            st_reg [2];
    logic [31:0]            st_next [2];
    logic [COUNT_WIDTH-1:0] sc_reg [2];
    logic [COUNT_WIDTH-1:0] sc_next [2];
    logic [31:0]            sm_reg [2];
    logic [31:0]            sm_next [2];
    logic [31:0]            zt_reg [2];
    logic [31:0]            zt_next [2];
    logic [31:0]            ic_reg, ic_next;
    logic [31:0]            lf_reg, lf_next;
    logic [23:0]            dt_reg, dt_next;
    logic                   neg_reg, neg_next;
    logic [DW-1:0]          mag_reg, mag_next;
    logic [47:0]            sps_reg, sps_next;
    logic [18:0]            f_reg, f_next;
    logic [DW-1:0]          hi_reg, hi_next;
    logic                   mfset_reg, mfset_next;
    logic                   mv_reg, mv_next;
    logic [1:0]             oaxis_reg, oaxis_next;
    logic [15:0]            orel_reg, orel_next;
    logic [15:0]            oabs_reg, oabs_next;
    logic                   olast_reg, olast_next;

    mms_pkg::arith_req_t    req;
    mms_pkg::arith_rsp_t    rsp;

    logic                   s_fire;
    logic                   out_free;
    logic [15:0]            d [2];
    logic [23:0]            in_dt;
    logic [31:0]            in_frame;

    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !mv_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign d[0]     = s_tdata[15:0];
    assign d[1]     = s_tdata[31:16];
    assign in_dt    = s_tdata[87:64];
    assign in_frame = s_tdata[119:88];

    mms_arith u_arith (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req),
        .rsp     (rsp)
    );

    always_comb begin
        logic [32:0]            asum;
        logic [15:0]            dmag;
        logic [COUNT_WIDTH:0]   ssum;
        logic [31:0]            icsum;
        logic [31:0]            accv;
        logic [COUNT_WIDTH-1:0] cnt;
        logic [47:0]            spsv;
        logic [31:0]            zsum;
        logic [48:0]            dt16;
        logic [DW-1:0]          nmag;
        logic [DW-1:0]          qmag;
        logic [15:0]            qv;

        asum       = '0;
        dmag       = '0;
        ssum       = '0;
        icsum      = '0;
        accv       = '0;
        cnt        = '0;
        spsv       = '0;
        zsum       = '0;
        nmag       = '0;
        qmag       = '0;
        qv         = '0;
        state_next = state_reg;
        ret_next   = ret_reg;
        axis_next  = axis_reg;
        en_next    = en_reg;
        intv_next  = intv_reg;
        acc_next   = acc_reg;
        st_next    = st_reg;
        sc_next    = sc_reg;
        sm_next    = sm_reg;
        zt_next    = zt_reg;
        ic_next    = ic_reg;
        lf_next    = lf_reg;
        dt_next    = dt_reg;
        neg_next   = neg_reg;
        mag_next   = mag_reg;
        sps_next   = sps_reg;
        f_next     = f_reg;
        hi_next    = hi_reg;
        mfset_next = mfset_reg;
        mv_next    = mv_reg && !m_tready;
        oaxis_next = oaxis_reg;
        orel_next  = orel_reg;
        oabs_next  = oabs_reg;
        olast_next = olast_reg;
        req        = '0;
        req.op     = mms_pkg::OP_MUL;
        dt16       = 49'({dt_reg, 16'h0000});

        if (cfg_wr_en) begin
            case (cfg_addr)
                mms_pkg::CFG_SMOOTH_EN:  en_next   = cfg_wr_data[0];
                mms_pkg::CFG_SAMPLE_INT: intv_next = cfg_wr_data;
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_fire && !s_tuser[0]) begin
                    for (int i = 0; i < 2; i++) begin
                        asum = {acc_reg[i][31], acc_reg[i]} + {{17{d[i][15]}}, d[i]};
                        if (asum[32] != asum[31])
                            acc_next[i] = asum[32] ? 32'h80000000 : 32'h7FFFFFFF;
                        else
                            acc_next[i] = asum[31:0];
                        dmag = d[i][15] ? (~d[i] + 16'd1) : d[i];
                        ssum = {1'b0, sc_reg[i]} + (COUNT_WIDTH+1)'(dmag);
                        sc_next[i] = ssum[COUNT_WIDTH] ? '1 : ssum[COUNT_WIDTH-1:0];
                        if (lf_reg != in_frame && d[i] != 16'd0 && sm_reg[i] != 32'd0)
                            st_next[i] = addu32(st_reg[i], in_dt);
                    end
                    lf_next    = in_frame;
                    mv_next    = 1'b1;
                    oaxis_next = mms_pkg::AXIS_Z;
                    orel_next  = s_tdata[63:48];
                    oabs_next  = s_tdata[47:32];
                    olast_next = 1'b1;
                end else if (s_fire) begin
                    icsum   = addu32(ic_reg, in_dt);
                    ic_next = icsum;
                    if (icsum >= 32'(intv_reg)) begin
                        axis_next  = 1'b0;
                        dt_next    = in_dt;
                        state_next = ST_AX;
                    end
                end
            end
            ST_AX: begin
                accv     = acc_reg[axis_reg];
                neg_next = accv[31];
                mag_next = {16'h0000, (accv[31] ? (~accv + 32'd1) : accv), 16'h0000};
                acc_next[axis_reg] = '0;
                state_next = ST_SCALE;
                if (en_reg) begin
                    if (dt_reg >= mms_pkg::DT_LIMIT) begin
                        sm_next[axis_reg] = '0;
                        zt_next[axis_reg] = '0;
                    end else begin
                        cnt = (sc_reg[axis_reg] == '0) ? COUNT_WIDTH'(1) : sc_reg[axis_reg];
                        req.start  = 1'b1;
                        req.op     = mms_pkg::OP_DIV;
                        req.a      = {16'h0000, st_reg[axis_reg], 16'h0000};
                        req.b      = DW'(cnt);
                        ret_next   = ST_SPS;
                        state_next = ST_WAIT;
                    end
                end
            end
            ST_WAIT: begin
                if (rsp.done) state_next = ret_reg;
            end
            ST_SPS: begin
                spsv       = (rsp.result == '0) ? 48'd1 : rsp.result[47:0];
                sps_next   = spsv;
                req.start  = 1'b1;
                req.op     = mms_pkg::OP_DIV;
                req.a      = {8'h00, dt_reg, 32'h00000000};
                req.b      = DW'(spsv);
                ret_next   = ST_FRAC;
                state_next = ST_WAIT;
            end
            ST_FRAC: begin
                f_next = (rsp.result > DW'(mms_pkg::FRAC_CAP)) ? mms_pkg::FRAC_CAP
                                                               : rsp.result[18:0];
                state_next = ST_SCALE;
                if (mag_reg == '0) begin
                    zsum = addu32(zt_reg[axis_reg], dt_reg);
                    zt_next[axis_reg] = zsum;
                    if ({zsum, 16'h0000} < sps_reg) begin
                        // decay the held smoothed value over this frame
                        neg_next   = sm_reg[axis_reg][31];
                        mag_next   = DW'(sm_reg[axis_reg][31] ? (~sm_reg[axis_reg] + 32'd1)
                                                              : sm_reg[axis_reg]);
                        mfset_next = 1'b0;
                        state_next = ST_MF_HI;
                    end else begin
                        sm_next[axis_reg] = '0;
                    end
                end else begin
                    zt_next[axis_reg] = '0;
                    if (sm_reg[axis_reg] == 32'd0) begin
                        sm_next[axis_reg] = sat32(neg_reg, mag_reg);
                    end else if (dt16 < {sps_reg, 1'b0}) begin
                        mfset_next = 1'b1;
                        state_next = ST_MF_HI;
                    end else begin
                        req.start  = 1'b1;
                        req.op     = mms_pkg::OP_DIV;
                        req.a      = DW'(dt16) + DW'(sps_reg[47:1]);
                        req.b      = DW'(sps_reg);
                        ret_next   = ST_NDIV;
                        state_next = ST_WAIT;
                    end
                end
            end
            ST_MF_HI: begin
                req.start  = 1'b1;
                req.op     = mms_pkg::OP_MUL;
                req.a      = {16'h0000, mag_reg[DW-1:16]};
                req.b      = DW'(f_reg);
                ret_next   = ST_MF_LO;
                state_next = ST_WAIT;
            end
            ST_MF_LO: begin
                hi_next    = rsp.result;
                req.start  = 1'b1;
                req.op     = mms_pkg::OP_MUL;
                req.a      = DW'(mag_reg[15:0]);
                req.b      = DW'(f_reg);
                ret_next   = ST_MF_SUM;
                state_next = ST_WAIT;
            end
            ST_MF_SUM: begin
                nmag     = hi_reg + {16'h0000, rsp.result[DW-1:16]};
                mag_next = nmag;
                if (mfset_reg) sm_next[axis_reg] = sat32(neg_reg, nmag);
                state_next = ST_SCALE;
            end
            ST_NDIV: begin
                req.start  = 1'b1;
                req.op     = mms_pkg::OP_DIV;
                req.a      = mag_reg;
                req.b      = rsp.result;
                ret_next   = ST_NQ;
                state_next = ST_WAIT;
            end
            ST_NQ: begin
                sm_next[axis_reg] = sat32(neg_reg, rsp.result);
                state_next = ST_SCALE;
            end
            ST_SCALE: begin
                if (ic_reg == 32'd0) begin
                    state_next = ST_EMIT;
                end else begin
                    req.start  = 1'b1;
                    req.op     = mms_pkg::OP_MUL;
                    req.a      = mag_reg;
                    req.b      = mms_pkg::OUT_SCALE;
                    ret_next   = ST_SDIV;
                    state_next = ST_WAIT;
                end
            end
            ST_SDIV: begin
                req.start  = 1'b1;
                req.op     = mms_pkg::OP_DIV;
                req.a      = rsp.result;
                req.b      = DW'(ic_reg);
                ret_next   = ST_EMIT;
                state_next = ST_WAIT;
            end
            ST_EMIT: begin
                if (ic_reg == 32'd0) qmag = (mag_reg != '0) ? DW'(32768) : '0;
                else                 qmag = rsp.result;
                // negate and clamp to Q1.15
                if (neg_reg) qv = (qmag > DW'(32767)) ? 16'h7FFF : qmag[15:0];
                else         qv = (qmag > DW'(32768)) ? 16'h8000 : (~qmag[15:0] + 16'd1);
                if (out_free) begin
                    mv_next    = 1'b1;
                    oaxis_next = axis_reg ? mms_pkg::AXIS_Y : mms_pkg::AXIS_X;
                    orel_next  = qv;
                    oabs_next  = qv;
                    olast_next = axis_reg;
                    if (!axis_reg) begin
                        axis_next  = 1'b1;
                        state_next = ST_AX;
                    end else begin
                        ic_next    = '0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ret_reg   <= ST_IDLE;
            axis_reg  <= 1'b0;
            en_reg    <= 1'b0;
            intv_reg  <= mms_pkg::SAMPLE_INTERVAL_RST;
            for (int i = 0; i < 2; i++) begin
                acc_reg[i] <= '0;
                st_reg[i]  <= mms_pkg::SAMPLING_TIME_RST;
                sc_reg[i]  <= COUNT_WIDTH'(1);
                sm_reg[i]  <= '0;
                zt_reg[i]  <= '0;
            end
            ic_reg    <= '0;
            lf_reg    <= '0;
            mv_reg    <= 1'b0;
            mfset_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            axis_reg  <= axis_next;
            en_reg    <= en_next;
            intv_reg  <= intv_next;
            acc_reg   <= acc_next;
            st_reg    <= st_next;
            sc_reg    <= sc_next;
            sm_reg    <= sm_next;
            zt_reg    <= zt_next;
            ic_reg    <= ic_next;
            lf_reg    <= lf_next;
            mv_reg    <= mv_next;
            mfset_reg <= mfset_next;
        end
        dt_reg    <= dt_next;
        neg_reg   <= neg_next;
        mag_reg   <= mag_next;
        sps_reg   <= sps_next;
        f_reg     <= f_next;
        hi_reg    <= hi_next;
        oaxis_reg <= oaxis_next;
        orel_reg  <= orel_next;
        oabs_reg  <= oabs_next;
        olast_reg <= olast_next;
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = {oabs_reg, orel_reg};
    assign m_tuser  = oaxis_reg;
    assign m_tlast  = olast_reg;

endmodule
`default_nettype wire

// ----- rtl/mms_arith.sv -----
// Shared iterative arithmetic unit: shift-add multiply and restoring divide,
// one bit per cycle. Depends on mms_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mms_arith (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire mms_pkg::arith_req_t req,
    output mms_pkg::arith_rsp_t     rsp
);

    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    mms_pkg::op_t                op_reg, op_next;
    logic [mms_pkg::STEP_W-1:0]  cnt_reg, cnt_next;
    logic [mms_pkg::DW-1:0]      q_reg, q_next;
    logic [mms_pkg::DW-1:0]      a_reg, a_next;
    logic [mms_pkg::DW-1:0]      b_reg, b_next;
    logic [mms_pkg::DW-1:0]      r_reg, r_next;
    logic [mms_pkg::DW+1:0]      trial;

    assign trial = {1'b0, r_reg, q_reg[mms_pkg::DW-1]} - {2'b00, b_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        r_next    = r_reg;
        if (req.start) begin
            busy_next = 1'b1;
            op_next   = req.op;
            r_next    = '0;
            if (req.op == mms_pkg::OP_DIV) begin
                q_next   = req.a;
                b_next   = req.b;
                cnt_next = mms_pkg::STEP_W'(mms_pkg::DIV_STEPS);
            end else begin
                a_next   = req.a;
                q_next   = req.b;
                cnt_next = mms_pkg::STEP_W'(mms_pkg::MUL_STEPS);
            end
        end else if (busy_reg) begin
            case (op_reg)
                mms_pkg::OP_DIV: begin
                    if (!trial[mms_pkg::DW+1]) begin
                        r_next = trial[mms_pkg::DW-1:0];
                        q_next = {q_reg[mms_pkg::DW-2:0], 1'b1};
                    end else begin
                        r_next = {r_reg[mms_pkg::DW-2:0], q_reg[mms_pkg::DW-1]};
                        q_next = {q_reg[mms_pkg::DW-2:0], 1'b0};
                    end
                end
                default: begin
                    if (q_reg[0]) r_next = r_reg + a_reg;
                    a_next = {a_reg[mms_pkg::DW-2:0], 1'b0};
                    q_next = {1'b0, q_reg[mms_pkg::DW-1:1]};
                end
            endcase
            cnt_next = cnt_reg - mms_pkg::STEP_W'(1);
            if (cnt_reg == mms_pkg::STEP_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= mms_pkg::OP_MUL;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            op_reg   <= op_next;
            cnt_reg  <= cnt_next;
        end
        q_reg <= q_next;
        a_reg <= a_next;
        b_reg <= b_next;
        r_reg <= r_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.result = (op_reg == mms_pkg::OP_DIV) ? q_reg : r_reg;

endmodule
`default_nettype wire

// ----- rtl/mms_checker.sv -----
// Port-level checker for mouse_motion_smoother, bound to the top level.
// Depends on mms_pkg for the axis codes.
`timescale 1ns / 1ps
`default_nettype none
module mms_checker (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         s_tvalid,
    input wire logic         s_tready,
    input wire logic [0:0]   s_tuser,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [1:0]   m_tuser,
    input wire logic         m_tlast
);

    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_motion_z: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !s_tuser[0] |=>
            m_tvalid && m_tuser == mms_pkg::AXIS_Z && m_tlast)
        else $error("motion request did not give a wheel result");

    a_x_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == mms_pkg::AXIS_X |-> !m_tlast)
        else $error("X result marked last");

    a_axis_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser == mms_pkg::AXIS_X || m_tuser == mms_pkg::AXIS_Y ||
                     m_tuser == mms_pkg::AXIS_Z)
        else $error("bad axis code");

endmodule

bind mouse_motion_smoother mms_checker u_mms_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
`default_nettype wire

// ----- dv/testbench.sv -----
// Self-checking bench for mouse_motion_smoother: directed table then random phases,
// each result checked against the table's expected values or an in-bench model of the smoother.
// Depends on rtl/mms_pkg.sv and rtl/mouse_motion_smoother.sv.
`timescale 1ns / 1ps
module testbench;

    localparam int  LIMIT_CYCLES = 3000000;
    localparam int  SETTLE       = 800;
    localparam int  RANDOM_ITEMS = 800;

    typedef struct {
        logic               kind;
        logic signed [15:0] rx;
        logic signed [15:0] ry;
        logic signed [15:0] wa;
        logic signed [15:0] wr;
        logic [23:0]        dt;
        logic [31:0]        fn;
    } motion_req_t;

    typedef struct {
        logic [1:0]  axis;
        logic [15:0] rel;
        logic [15:0] abs;
        logic        last;
    } axis_res_t;

    typedef struct {
        bit        typed;
        int        n;
        axis_res_t r0;
        axis_res_t r1;
    } typed_exp_t;

    typedef enum int { ROW_REQ, ROW_CFG } row_kind_t;

    typedef struct {
        row_kind_t   rk;
        logic        cfg_idx;
        logic [19:0] cfg_val;
        motion_req_t req;
        typed_exp_t  te;
    } row_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [119:0] s_tdata = '0;
    logic [0:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [31:0]  m_tdata;
    logic [1:0]   m_tuser;
    logic         m_tlast;
    logic         cfg_wr_en = 1'b0;
    logic [0:0]   cfg_addr = '0;
    logic [19:0]  cfg_wr_data = '0;

    mouse_motion_smoother dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wr_data(cfg_wr_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // model state
    logic        mdl_smooth_en;
    logic [19:0] mdl_interval;
    int          mdl_acc [2];
    logic [31:0] mdl_samp_time [2];
    logic [63:0] mdl_count [2];
    int          mdl_smoothed [2];
    logic [31:0] mdl_zero_time [2];
    logic [31:0] mdl_icount;
    logic [31:0] mdl_last_frame;

    axis_res_t  axis_expected [$];
    axis_res_t  model_out [$];
    typed_exp_t typed_q [$];

    int errors = 0;
    int cycles = 0;
    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int hold_request = 0;
    int hold_left = 0;
    logic [31:0] frame_ctr = 0;

    function automatic logic [31:0] add_sat(logic [31:0] a, logic [63:0] b);
        logic [63:0] s;
        s = {32'd0, a} + b;
        return (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic int sat_int(longint v);
        if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'sh8000_0000;
        return int'(v);
    endfunction

    function automatic longint frac_mul(longint v, logic [63:0] f);
        logic [63:0] mag, r;
        mag = (v < 0) ? 64'(-v) : 64'(v);
        r = (mag >> 16) * f + (((mag & 64'hFFFF) * f) >> 16);
        return (v < 0) ? -longint'(r) : longint'(r);
    endfunction

    function automatic longint smooth_one(longint value, int i, logic [63:0] dt);
        logic [63:0] cnt, sps, f, dt16;
        longint n;
        if (dt >= 64'(mms_pkg::DT_LIMIT)) begin
            mdl_smoothed[i] = 0;
            mdl_zero_time[i] = 0;
            return value;
        end
        cnt = (mdl_count[i] != 0) ? mdl_count[i] : 64'd1;
        sps = ({32'd0, mdl_samp_time[i]} << 16) / cnt;
        if (sps == 0) sps = 1;
        f = (dt << 32) / sps;
        if (f > 64'(mms_pkg::FRAC_CAP)) f = 64'(mms_pkg::FRAC_CAP);
        dt16 = dt << 16;
        if (value == 0) begin
            mdl_zero_time[i] = add_sat(mdl_zero_time[i], dt);
            if (({32'd0, mdl_zero_time[i]} << 16) < sps)
                value = frac_mul(longint'(mdl_smoothed[i]), f);
            else
                mdl_smoothed[i] = 0;
        end else begin
            n = 1;
            mdl_zero_time[i] = 0;
            if (mdl_smoothed[i] != 0) begin
                if (dt16 < 2 * sps)
                    value = frac_mul(value, f);
                else
                    n = longint'((dt16 + sps / 2) / sps);
            end
            mdl_smoothed[i] = sat_int(value / n);
        end
        return value;
    endfunction

    function automatic logic [15:0] clamp_q15(longint v);
        longint q;
        if (mdl_icount == 0)
            q = (v > 0) ? 32768 : ((v < 0) ? -32768 : 0);
        else
            q = (v * 250) / longint'({32'd0, mdl_icount});
        q = -q;
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        return q[15:0];
    endfunction

    function automatic void model_reset();
        mdl_smooth_en = 1'b0;
        mdl_interval = mms_pkg::SAMPLE_INTERVAL_RST;
        for (int i = 0; i < 2; i++) begin
            mdl_acc[i] = 0;
            mdl_samp_time[i] = mms_pkg::SAMPLING_TIME_RST;
            mdl_count[i] = 1;
            mdl_smoothed[i] = 0;
            mdl_zero_time[i] = 0;
        end
        mdl_icount = 0;
        mdl_last_frame = 0;
    endfunction

    // append the results of one request to model_out
    function automatic void model_step(motion_req_t q);
        longint d [2];
        logic [63:0] mag, cmax;
        longint v;
        axis_res_t r;
        cmax = 64'hFFFF_FFFF;
        if (q.kind == 1'b0) begin
            d[0] = longint'(q.rx);
            d[1] = longint'(q.ry);
            for (int i = 0; i < 2; i++) begin
                mag = (d[i] < 0) ? 64'(-d[i]) : 64'(d[i]);
                mdl_acc[i] = sat_int(longint'(mdl_acc[i]) + d[i]);
                mdl_count[i] = (mdl_count[i] > cmax - mag) ? cmax : mdl_count[i] + mag;
            end
            if (mdl_last_frame != q.fn) begin
                for (int i = 0; i < 2; i++)
                    if (d[i] != 0 && mdl_smoothed[i] != 0)
                        mdl_samp_time[i] = add_sat(mdl_samp_time[i], 64'(q.dt));
                mdl_last_frame = q.fn;
            end
            r.axis = mms_pkg::AXIS_Z; r.rel = q.wr; r.abs = q.wa; r.last = 1'b1;
            model_out = {model_out, r};
            return;
        end
        mdl_icount = add_sat(mdl_icount, 64'(q.dt));
        if (mdl_icount < {12'd0, mdl_interval}) return;
        for (int i = 0; i < 2; i++) begin
            v = longint'(mdl_acc[i]) * 65536;
            if (mdl_smooth_en) v = smooth_one(v, i, 64'(q.dt));
            mdl_acc[i] = 0;
            r.axis = (i == 0) ? mms_pkg::AXIS_X : mms_pkg::AXIS_Y;
            r.rel = clamp_q15(v);
            r.abs = r.rel;
            r.last = (i == 1);
            model_out = {model_out, r};
        end
        mdl_icount = 0;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        errors++;
        $display("mismatch at cycle %0d: %s got %0h want %0h", cycles, what, got, want);
    endtask

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // scoreboard: predict on accepted requests, compare accepted results
    always @(posedge aclk) begin
        motion_req_t q;
        typed_exp_t te;
        axis_res_t want;
        if (!aresetn) begin
            model_reset();
        end else begin
            if (cfg_wr_en) begin
                if (cfg_addr == mms_pkg::CFG_SMOOTH_EN) mdl_smooth_en = cfg_wr_data[0];
                else mdl_interval = cfg_wr_data;
            end
            if (s_tvalid && s_tready) begin
                q.kind = s_tuser[0];
                {q.fn, q.dt, q.wr, q.wa, q.ry, q.rx} = s_tdata;
                model_out.delete();
                model_step(q);
                te = typed_q.pop_front();
                if (te.typed) begin
                    if (te.n > 0) axis_expected = {axis_expected, te.r0};
                    if (te.n > 1) axis_expected = {axis_expected, te.r1};
                end else begin
                    foreach (model_out[k]) axis_expected = {axis_expected, model_out[k]};
                end
            end
            if (m_tvalid && m_tready) begin
                if (axis_expected.size() == 0) begin
                    report_mismatch("unexpected result axis", 32'(m_tuser), 0);
                end else begin
                    want = axis_expected.pop_front();
                    if (m_tuser !== want.axis) report_mismatch("axis", 32'(m_tuser), 32'(want.axis));
                    if (m_tdata[15:0] !== want.rel)
                        report_mismatch("rel_value", 32'(m_tdata[15:0]), 32'(want.rel));
                    if (m_tdata[31:16] !== want.abs)
                        report_mismatch("abs_value", 32'(m_tdata[31:16]), 32'(want.abs));
                    if (m_tlast !== want.last) report_mismatch("last", 32'(m_tlast), 32'(want.last));
                end
            end
        end
    end

    // receiver: random stalls, plus a long hold when requested
    always @(negedge aclk) begin
        if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    task automatic send_req(motion_req_t q, typed_exp_t te);
        @(negedge aclk);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        typed_q = {typed_q, te};
        s_tvalid <= 1'b1;
        s_tuser  <= q.kind;
        s_tdata  <= {q.fn, q.dt, q.wr, q.wa, q.ry, q.rx};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (axis_expected.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [19:0] val);
        drain();
        @(negedge aclk);
        cfg_wr_en <= 1'b1; cfg_addr <= idx; cfg_wr_data <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [15:0] rand_delta();
        int p;
        p = $urandom_range(99);
        if (p < 10) return 16'd0;
        if (p < 80) return 16'($signed($urandom_range(100)) - 50);
        return 16'($urandom);
    endfunction

    function automatic motion_req_t rand_req();
        motion_req_t q;
        int p;
        q.kind = ($urandom_range(99) < 30);
        q.rx = rand_delta(); q.ry = rand_delta();
        q.wa = 16'($urandom); q.wr = 16'($urandom);
        p = $urandom_range(99);
        if (q.kind) begin
            if (p < 80) q.dt = 24'($urandom_range(9000, 500));
            else if (p < 90) q.dt = 24'($urandom_range(300000, 240000));
            else if (p < 95) q.dt = 24'($urandom);
            else q.dt = 24'd0;
        end else begin
            q.dt = (p < 90) ? 24'($urandom_range(20000, 1000)) : 24'($urandom);
        end
        p = $urandom_range(99);
        if (p < 40) frame_ctr = frame_ctr + 1;
        else if (p < 45) frame_ctr = $urandom;
        q.fn = frame_ctr;
        return q;
    endfunction

    function automatic motion_req_t mk(logic kind, int rx, int ry, int wa, int wr,
                                       int unsigned dt, int unsigned fn);
        motion_req_t q;
        q.kind = kind; q.rx = 16'(rx); q.ry = 16'(ry); q.wa = 16'(wa); q.wr = 16'(wr);
        q.dt = 24'(dt); q.fn = 32'(fn);
        return q;
    endfunction

    row_t table_rows [$];

    function automatic void add_req(motion_req_t q, bit typed, int n, axis_res_t r0, axis_res_t r1);
        row_t r;
        r.rk = ROW_REQ; r.req = q;
        r.te.typed = typed; r.te.n = n; r.te.r0 = r0; r.te.r1 = r1;
        table_rows = {table_rows, r};
    endfunction

    function automatic void add_cfg(logic idx, logic [19:0] val);
        row_t r;
        r.rk = ROW_CFG; r.cfg_idx = idx; r.cfg_val = val;
        table_rows = {table_rows, r};
    endfunction

    function automatic axis_res_t res(logic [1:0] a, int rel, int abs, logic last);
        axis_res_t r;
        r.axis = a; r.rel = 16'(rel); r.abs = 16'(abs); r.last = last;
        return r;
    endfunction

    function automatic void build_table();
        axis_res_t z;
        z = res(mms_pkg::AXIS_Z, 0, 0, 1'b0);
        // tick below the interval: nothing; tick at the interval with no motion: zeros
        add_req(mk(1, 0, 0, 0, 0, 5999, 0), 1, 0, z, z);
        add_req(mk(1, 0, 0, 0, 0, 1, 0), 1, 2, res(mms_pkg::AXIS_X, 0, 0, 0),
                res(mms_pkg::AXIS_Y, 0, 0, 1));
        // extremes of the motion fields; the wheel passes through
        add_req(mk(0, -32768, 32767, -32768, 32767, 16777215, 32'hFFFF_FFFF), 1, 1,
                res(mms_pkg::AXIS_Z, 32767, -32768, 1), z);
        add_req(mk(0, 32767, -32768, 32767, -32768, 0, 0), 1, 1,
                res(mms_pkg::AXIS_Z, -32768, 32767, 1), z);
        add_req(mk(1, 0, 0, 0, 0, 6000, 0), 0, 0, z, z);
        add_req(mk(0, 5, -3, 0, 0, 16000, 1), 0, 0, z, z);
        add_req(mk(1, 0, 0, 0, 0, 16777215, 0), 0, 0, z, z);
        // smoothing on: build a nonzero smoothed value, then zero motion, then a long frame
        add_cfg(mms_pkg::CFG_SMOOTH_EN, 20'd1);
        add_req(mk(0, 40, -40, 1, 2, 8000, 2), 0, 0, z, z);
        add_req(mk(1, 0, 0, 0, 0, 8000, 0), 0, 0, z, z);
        add_req(mk(0, 30, -20, 3, 4, 8000, 3), 0, 0, z, z);
        add_req(mk(1, 0, 0, 0, 0, 8000, 0), 0, 0, z, z);
        add_req(mk(1, 0, 0, 0, 0, 8000, 0), 0, 0, z, z);
        add_req(mk(0, 12, 7, 0, 0, 8000, 4), 0, 0, z, z);
        add_req(mk(1, 0, 0, 0, 0, 60000, 0), 0, 0, z, z);
        add_req(mk(0, 9, -9, 0, 0, 8000, 5), 0, 0, z, z);
        add_req(mk(1, 0, 0, 0, 0, 250000, 0), 0, 0, z, z);
        // zero interval: a tick of zero length closes at once
        add_cfg(mms_pkg::CFG_SAMPLE_INT, 20'd0);
        add_req(mk(0, -7, 3, 0, 0, 100, 6), 0, 0, z, z);
        add_req(mk(1, 0, 0, 0, 0, 0, 0), 0, 0, z, z);
        add_req(mk(1, 0, 0, 0, 0, 0, 0), 0, 0, z, z);
        add_cfg(mms_pkg::CFG_SAMPLE_INT, 20'd1000000);
        add_req(mk(0, 100, 100, 0, 0, 100, 7), 0, 0, z, z);
        add_req(mk(1, 0, 0, 0, 0, 999999, 0), 0, 0, z, z);
        add_req(mk(1, 0, 0, 0, 0, 1, 0), 0, 0, z, z);
    endfunction

    initial begin
        typed_exp_t none;
        motion_req_t q;
        int n_phase;
        logic [19:0] iv;
        none.typed = 0; none.n = 0;
        build_table();
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (table_rows[i]) begin
            if (table_rows[i].rk == ROW_CFG)
                write_reg(table_rows[i].cfg_idx, table_rows[i].cfg_val);
            else
                send_req(table_rows[i].req, table_rows[i].te);
        end

        n_phase = 0;
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 68; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 68; end
                default: begin tx_idle_pct = 15; rx_stall_pct = 15; end
            endcase
            case (ph)
                0: iv = 20'd6000;
                1: iv = 20'd0;
                2: iv = 20'd1000000;
                default: iv = 20'($urandom_range(20000, 1));
            endcase
            write_reg(mms_pkg::CFG_SMOOTH_EN, 20'($urandom));
            write_reg(mms_pkg::CFG_SAMPLE_INT, iv);
            for (int k = 0; k < RANDOM_ITEMS / 8; k++) begin
                if (ph == 4 && k == 20) begin
                    @(posedge aclk);
                    hold_request = 3000;
                end
                if (ph == 5 && k == 50) drain();
                q = rand_req();
                send_req(q, none);
            end
        end

        drain();
        if (axis_expected.size() != 0)
            report_mismatch("results still owed", 32'(axis_expected.size()), 0);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
